@@ rtl/iwo_pkg.sv @@
package iwo_pkg;

    localparam int CORDIC_N    = 24;
    localparam int CORDIC_IW   = 5;
    localparam int CORDIC_W    = 44;
    localparam int NORM_BIT    = 40;
    localparam int CORDIC_GAIN = 652032874;
    localparam int APB_ADDR_W  = 4;
    localparam int MUL_W       = 33;

    typedef enum logic [1:0] {
        OP_UPDATE   = 2'd0,
        OP_SET_POSE = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_NOP      = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_INCHES   = 2'd0,
        REG_TARGET_X = 2'd1,
        REG_TARGET_Y = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_ROT,
        ST_STEP_X,
        ST_STEP_Y,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQRT,
        ST_BEAR,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        CP_IDLE,
        CP_NORM,
        CP_ITER
    } t_cor_phase;

    typedef struct packed {
        logic start;
        logic vectoring;
    } t_cordic_req;

    // arctan(2^-i) in 2^32 units per turn
    function automatic logic [29:0] atan_entry(input logic [CORDIC_IW-1:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/iwo_mul.sv @@
module iwo_mul #(
    parameter int W = 33
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [2*W-1:0] o_prod,
    output logic           o_done
);
    localparam int CW = $clog2(W);

    logic [2*W-1:0] r_acc, r_mcand;
    logic [W-1:0]   r_mplier;
    logic [CW-1:0]  r_cnt;
    logic           r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= {{W{1'b0}}, i_a};
            r_mplier <= i_b;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;
endmodule

@@ rtl/iwo_isqrt.sv @@
module iwo_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root,
    output logic        o_done
);
    logic [63:0] r_n;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [35:0] rem_sh, trial, diff;
    logic        fits;

    always_comb begin
        rem_sh = {r_rem, r_n[63:62]};
        trial  = {2'b00, r_root, 2'b01};
        diff   = rem_sh - trial;
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // two radicand bits per root bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n <= r_n << 2;
            if (fits) begin
                r_rem  <= diff[33:0];
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[33:0];
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;
endmodule

@@ rtl/iwo_cordic.sv @@
module iwo_cordic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iwo_pkg::t_cordic_req i_req,
    input  logic [31:0]         i_angle,
    input  logic signed [32:0]  i_num,
    input  logic signed [32:0]  i_den,
    output logic signed [31:0]  o_cos,
    output logic signed [31:0]  o_sin,
    output logic [31:0]         o_bearing,
    output logic                o_done
);
    localparam int W  = iwo_pkg::CORDIC_W;
    localparam int IW = iwo_pkg::CORDIC_IW;
    localparam logic signed [W-1:0]  GAIN    = W'(iwo_pkg::CORDIC_GAIN);
    localparam logic signed [W-1:0]  NORM_HI = W'(1) << iwo_pkg::NORM_BIT;
    localparam logic signed [W-1:0]  NORM_LO = -NORM_HI;
    localparam logic signed [33:0]   QUARTER = 34'sd1 << 30;
    localparam logic signed [33:0]   HALF    = 34'sd1 << 31;

    iwo_pkg::t_cor_phase r_phase, n_phase;
    logic signed [W-1:0] r_x, r_y, xs, ys;
    logic signed [33:0]  r_z, z_in, z_rot, at;
    logic [IW-1:0]       r_i;
    logic                r_flip, r_vec, r_done, n_done;
    logic                flip_rot, big, zero_vec, s_pos;

    always_comb begin
        z_in     = {{2{i_angle[31]}}, i_angle};
        flip_rot = 1'b0;
        z_rot    = z_in;
        if (z_in > QUARTER) begin
            z_rot    = z_in - HALF;
            flip_rot = 1'b1;
        end else if (z_in < -QUARTER) begin
            z_rot    = z_in + HALF;
            flip_rot = 1'b1;
        end
        zero_vec = (i_num == '0) && (i_den == '0);
        big      = (r_x >= NORM_HI) || (r_x <= NORM_LO) || (r_y >= NORM_HI) || (r_y <= NORM_LO);
        xs       = r_x >>> r_i;
        ys       = r_y >>> r_i;
        at       = {4'b0, iwo_pkg::atan_entry(r_i)};
        // rotate toward zero angle, or toward the x axis when vectoring
        s_pos    = r_vec ? !(r_y > 0) : !r_z[33];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= iwo_pkg::CP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_done  = 1'b0;
        unique case (r_phase)
            iwo_pkg::CP_IDLE: begin
                if (i_req.start) begin
                    if (!i_req.vectoring) begin
                        n_phase = iwo_pkg::CP_ITER;
                    end else if (zero_vec) begin
                        n_done = 1'b1;
                    end else begin
                        n_phase = iwo_pkg::CP_NORM;
                    end
                end
            end
            iwo_pkg::CP_NORM: begin
                if (big) begin
                    n_phase = iwo_pkg::CP_ITER;
                end
            end
            iwo_pkg::CP_ITER: begin
                if (r_i == IW'(iwo_pkg::CORDIC_N - 1)) begin
                    n_phase = iwo_pkg::CP_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: n_phase = iwo_pkg::CP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            iwo_pkg::CP_IDLE: begin
                if (i_req.start) begin
                    r_vec <= i_req.vectoring;
                    r_i   <= '0;
                    if (i_req.vectoring) begin
                        r_x    <= W'(i_den);
                        r_y    <= W'(i_num);
                        r_z    <= '0;
                        r_flip <= 1'b0;
                    end else begin
                        r_x    <= GAIN;
                        r_y    <= '0;
                        r_z    <= z_rot;
                        r_flip <= flip_rot;
                    end
                end
            end
            iwo_pkg::CP_NORM: begin
                if (big) begin
                    if (r_x < 0) begin
                        r_x <= -r_x;
                        r_y <= -r_y;
                        r_z <= HALF;
                    end
                end else begin
                    r_x <= r_x <<< 1;
                    r_y <= r_y <<< 1;
                end
            end
            iwo_pkg::CP_ITER: begin
                if (s_pos) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                r_i <= r_i + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_cos     = 32'(r_flip ? -r_x : r_x);
    assign o_sin     = 32'(r_flip ? -r_y : r_y);
    assign o_bearing = r_z[31:0];
    assign o_done    = r_done;
endmodule

@@ rtl/imu_wheel_odometry.sv @@
// channel | valid       | ready       | payload
// input   | i_in_valid  | o_in_ready  | i_opcode .. i_pose_angle
// result  | o_out_valid | i_out_ready | o_out_x .. o_back_angle_error
// config  | psel/penable/pwrite, paddr, pwdata, prdata, pready always high
//
// one item at a time, ready only in idle; an update runs the distance multiply, the
// rotation, two step multiplies, two squaring multiplies, the square root and vectoring;
// set pose, clear and no-op run only the squares, root and vectoring, which first normalizes
// by shifts and ends at once when the target sits at the robot; the done state then waits
// for room for the result; reset is synchronous, active low, and zeros the pose and the registers
// a result held by the sink stalls completion of the next item only
module imu_wheel_odometry #(
    parameter int ANGLE_BITS    = 16,
    parameter int POS_FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_opcode,
    input  logic signed [31:0]           i_left_count,
    input  logic signed [31:0]           i_right_count,
    input  logic [ANGLE_BITS-1:0]        i_imu_angle,
    input  logic signed [31:0]           i_pose_x,
    input  logic signed [31:0]           i_pose_y,
    input  logic [ANGLE_BITS-1:0]        i_pose_angle,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [31:0]           o_out_x,
    output logic signed [31:0]           o_out_y,
    output logic [ANGLE_BITS-1:0]        o_out_heading,
    output logic [31:0]                  o_target_distance,
    output logic signed [ANGLE_BITS-1:0] o_front_angle_error,
    output logic signed [ANGLE_BITS-1:0] o_back_angle_error,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [iwo_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    localparam int AB = ANGLE_BITS;
    localparam int MW = iwo_pkg::MUL_W;
    localparam int DIST_SHIFT = 25 - POS_FRAC_BITS;
    localparam logic [65:0] POS_MAX = 66'd2147483647;
    localparam logic [65:0] NEG_MAX = 66'd2147483648;
    localparam logic signed [64:0] ROUND_HALF = 65'sd1 << 29;
    localparam logic [31:0] BEAR_HALF = 32'd1 << (31 - AB);
    localparam logic [AB-1:0] HALF_TURN = AB'(1) << (AB - 1);

    iwo_pkg::t_state r_state, n_state;
    logic r_go, n_go;
    logic r_out_valid;

    logic [31:0]         r_inches;
    logic signed [31:0]  r_tx, r_ty, r_x, r_y;
    logic [AB-1:0]       r_heading, r_offset;
    logic [31:0]         r_last_l, r_last_r;

    logic [32:0]         r_mag;
    logic                r_sum_neg;
    logic [31:0]         r_dmag;
    logic                r_dneg;
    logic signed [31:0]  r_cos, r_sin;
    logic [63:0]         r_a2, r_rad;
    logic                r_sat;
    logic [31:0]         r_tdist;

    logic signed [31:0]  r_ox, r_oy;
    logic [AB-1:0]       r_oh, r_ofront, r_oback;
    logic [31:0]         r_odist;

    logic                in_acc, out_free;
    logic [31:0]         dl, dr;
    logic signed [32:0]  sum;
    logic signed [32:0]  dx, dy;
    logic [32:0]         adx, ady;
    logic [MW-1:0]       mul_a, mul_b;
    logic [2*MW-1:0]     mul_p;
    logic                mul_done, mul_start;
    logic [65:0]         prod_sh;
    logic [31:0]         dmag_next;
    logic [31:0]         sin_mag, cos_mag;
    logic                step_neg;
    logic signed [64:0]  step_p, step_r;
    logic signed [35:0]  pos_base, pos_sum;
    logic signed [31:0]  pos_sat;
    logic [64:0]         sq_sum;
    logic [31:0]         root;
    logic                sq_done;
    iwo_pkg::t_cordic_req cor_req;
    logic signed [31:0]  cor_cos, cor_sin;
    logic [31:0]         cor_bear, bear_sum;
    logic                cor_done;
    logic [AB-1:0]       bear;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == iwo_pkg::ST_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign pready     = 1'b1;

    always_comb begin
        dl  = i_left_count - r_last_l;
        dr  = i_right_count - r_last_r;
        sum = $signed({dl[31], dl}) + $signed({dr[31], dr});
        dx  = $signed({r_tx[31], r_tx}) - $signed({r_x[31], r_x});
        dy  = $signed({r_ty[31], r_ty}) - $signed({r_y[31], r_y});
        adx = dx[32] ? 33'(-dx) : 33'(dx);
        ady = dy[32] ? 33'(-dy) : 33'(dy);
        sin_mag = r_sin[31] ? 32'(-r_sin) : 32'(r_sin);
        cos_mag = r_cos[31] ? 32'(-r_cos) : 32'(r_cos);
    end

    always_comb begin
        unique case (r_state)
            iwo_pkg::ST_DIST: begin
                mul_a = r_mag;
                mul_b = {1'b0, r_inches};
            end
            iwo_pkg::ST_STEP_X: begin
                mul_a = {1'b0, r_dmag};
                mul_b = {1'b0, sin_mag};
            end
            iwo_pkg::ST_STEP_Y: begin
                mul_a = {1'b0, r_dmag};
                mul_b = {1'b0, cos_mag};
            end
            iwo_pkg::ST_SQ_X: begin
                mul_a = adx;
                mul_b = adx;
            end
            iwo_pkg::ST_SQ_Y: begin
                mul_a = ady;
                mul_b = ady;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_start = r_go && ((r_state == iwo_pkg::ST_DIST) ||
        (r_state == iwo_pkg::ST_STEP_X) || (r_state == iwo_pkg::ST_STEP_Y) ||
        (r_state == iwo_pkg::ST_SQ_X) || (r_state == iwo_pkg::ST_SQ_Y));

    iwo_mul #(.W(MW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_p),
        .o_done  (mul_done)
    );

    iwo_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && (r_state == iwo_pkg::ST_SQRT)),
        .i_rad   (r_rad),
        .o_root  (root),
        .o_done  (sq_done)
    );

    always_comb begin
        cor_req.start     = r_go && ((r_state == iwo_pkg::ST_ROT) ||
                                     (r_state == iwo_pkg::ST_BEAR));
        cor_req.vectoring = (r_state == iwo_pkg::ST_BEAR);
    end

    iwo_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (cor_req),
        .i_angle   ({r_heading, {(32 - AB){1'b0}}}),
        .i_num     (dx),
        .i_den     (dy),
        .o_cos     (cor_cos),
        .o_sin     (cor_sin),
        .o_bearing (cor_bear),
        .o_done    (cor_done)
    );

    always_comb begin
        // travel magnitude, clamped to what the signed range allows
        prod_sh = mul_p >> DIST_SHIFT;
        if (r_sum_neg) begin
            dmag_next = (prod_sh > NEG_MAX) ? NEG_MAX[31:0] : prod_sh[31:0];
        end else begin
            dmag_next = (prod_sh > POS_MAX) ? POS_MAX[31:0] : prod_sh[31:0];
        end
        step_neg = r_dneg ^ ((r_state == iwo_pkg::ST_STEP_X) ? r_sin[31] : r_cos[31]);
        step_p   = step_neg ? -$signed({1'b0, mul_p[63:0]}) : $signed({1'b0, mul_p[63:0]});
        step_r   = (step_p + ROUND_HALF) >>> 30;
        pos_base = (r_state == iwo_pkg::ST_STEP_X) ? 36'(r_x) : 36'(r_y);
        pos_sum  = pos_base + 36'(step_r);
        if (pos_sum > 36'sd2147483647) begin
            pos_sat = 32'sh7fffffff;
        end else if (pos_sum < -36'sd2147483648) begin
            pos_sat = 32'sh80000000;
        end else begin
            pos_sat = 32'(pos_sum);
        end
        sq_sum   = {1'b0, r_a2} + {1'b0, mul_p[63:0]};
        bear_sum = cor_bear + BEAR_HALF;
        bear     = bear_sum[31 -: AB];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iwo_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = (iwo_pkg::t_opcode'(i_opcode) == iwo_pkg::OP_UPDATE)
                              ? iwo_pkg::ST_DIST : iwo_pkg::ST_SQ_X;
                end
            end
            iwo_pkg::ST_DIST:   if (mul_done) n_state = iwo_pkg::ST_ROT;
            iwo_pkg::ST_ROT:    if (cor_done) n_state = iwo_pkg::ST_STEP_X;
            iwo_pkg::ST_STEP_X: if (mul_done) n_state = iwo_pkg::ST_STEP_Y;
            iwo_pkg::ST_STEP_Y: if (mul_done) n_state = iwo_pkg::ST_SQ_X;
            iwo_pkg::ST_SQ_X:   if (mul_done) n_state = iwo_pkg::ST_SQ_Y;
            iwo_pkg::ST_SQ_Y:   if (mul_done) n_state = iwo_pkg::ST_SQRT;
            iwo_pkg::ST_SQRT:   if (sq_done)  n_state = iwo_pkg::ST_BEAR;
            iwo_pkg::ST_BEAR:   if (cor_done) n_state = iwo_pkg::ST_DONE;
            iwo_pkg::ST_DONE:   if (out_free) n_state = iwo_pkg::ST_IDLE;
            default: n_state = iwo_pkg::ST_IDLE;
        endcase
        // a unit starts on the first cycle of its state
        n_go = (n_state != r_state);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iwo_pkg::ST_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
            r_inches    <= '0;
            r_tx        <= '0;
            r_ty        <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_heading   <= '0;
            r_offset    <= '0;
            r_last_l    <= '0;
            r_last_r    <= '0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            if (r_state == iwo_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (psel && penable && pwrite) begin
                case (iwo_pkg::t_reg_idx'(paddr[3:2]))
                    iwo_pkg::REG_INCHES:   r_inches <= pwdata;
                    iwo_pkg::REG_TARGET_X: r_tx     <= pwdata;
                    iwo_pkg::REG_TARGET_Y: r_ty     <= pwdata;
                    default: ;
                endcase
            end
            if (in_acc) begin
                unique case (iwo_pkg::t_opcode'(i_opcode))
                    iwo_pkg::OP_UPDATE: begin
                        r_heading <= i_imu_angle + r_offset;
                        r_last_l  <= i_left_count;
                        r_last_r  <= i_right_count;
                    end
                    iwo_pkg::OP_SET_POSE: begin
                        r_x       <= i_pose_x;
                        r_y       <= i_pose_y;
                        r_heading <= i_pose_angle;
                        r_offset  <= i_pose_angle;
                        r_last_l  <= i_left_count;
                        r_last_r  <= i_right_count;
                    end
                    iwo_pkg::OP_CLEAR: begin
                        r_x       <= '0;
                        r_y       <= '0;
                        r_heading <= '0;
                        r_last_l  <= '0;
                        r_last_r  <= '0;
                    end
                    default: ;
                endcase
            end
            if (mul_done && r_state == iwo_pkg::ST_STEP_X) begin
                r_x <= pos_sat;
            end
            if (mul_done && r_state == iwo_pkg::ST_STEP_Y) begin
                r_y <= pos_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sum_neg <= sum[32];
            r_mag     <= sum[32] ? 33'(-sum) : 33'(sum);
        end
        if (mul_done && r_state == iwo_pkg::ST_DIST) begin
            r_dmag <= dmag_next;
            r_dneg <= r_sum_neg;
        end
        if (cor_done && r_state == iwo_pkg::ST_ROT) begin
            r_cos <= cor_cos;
            r_sin <= cor_sin;
        end
        if (mul_done && r_state == iwo_pkg::ST_SQ_X) begin
            r_a2 <= mul_p[63:0];
        end
        if (mul_done && r_state == iwo_pkg::ST_SQ_Y) begin
            r_rad <= sq_sum[63:0];
            r_sat <= sq_sum[64];
        end
        if (sq_done) begin
            r_tdist <= r_sat ? 32'hffffffff : root;
        end
        if (r_state == iwo_pkg::ST_DONE && out_free) begin
            r_ox     <= r_x;
            r_oy     <= r_y;
            r_oh     <= r_heading;
            r_odist  <= r_tdist;
            r_ofront <= bear - r_heading;
            r_oback  <= bear + HALF_TURN - r_heading;
        end
    end

    always_comb begin
        case (iwo_pkg::t_reg_idx'(paddr[3:2]))
            iwo_pkg::REG_INCHES:   prdata = r_inches;
            iwo_pkg::REG_TARGET_X: prdata = r_tx;
            iwo_pkg::REG_TARGET_Y: prdata = r_ty;
            default:               prdata = '0;
        endcase
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_x             = r_ox;
    assign o_out_y             = r_oy;
    assign o_out_heading       = r_oh;
    assign o_target_distance   = r_odist;
    assign o_front_angle_error = r_ofront;
    assign o_back_angle_error  = r_oback;

    a_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == iwo_pkg::ST_DIST || r_state == iwo_pkg::ST_STEP_X ||
                      r_state == iwo_pkg::ST_STEP_Y || r_state == iwo_pkg::ST_SQ_X ||
                      r_state == iwo_pkg::ST_SQ_Y))
        else $error("multiplier finished outside a multiply state");

    a_cordic_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_done |-> (r_state == iwo_pkg::ST_ROT || r_state == iwo_pkg::ST_BEAR))
        else $error("cordic finished outside a cordic state");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != iwo_pkg::ST_IDLE && !o_in_ready))
        else $error("accepted item did not start work");
endmodule
